### hw/rtl/dcfp_pkg.sv
// ============================================================================
// dcfp_pkg - shared types and constants of the command frame parser
// Frame layout constants, decode helper and the record that travels from
// the classifier through the queue to the output stage.
// ============================================================================
`default_nettype none

package dcfp_pkg;

    // frame geometry
    localparam int unsigned MAX_FRAME   = 1024;
    localparam int unsigned LEN_W       = 11;
    localparam int unsigned HDR_FIELDS  = 5;
    localparam int unsigned HDR_FIRST   = 1;
    localparam int unsigned HDR_LAST    = 5;
    localparam int unsigned KEPT_SUBS   = 3;
    localparam int unsigned SUB_SLOTS   = 3;
    localparam int unsigned SUB_IDX_W   = $clog2(SUB_SLOTS);

    // queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // byte constants
    localparam logic [7:0] DECODE_BIAS = 8'h04;
    localparam logic [7:0] TOP_MASK    = 8'hC0;
    localparam logic [7:0] CMD_MASK    = 8'h3F;
    localparam logic [7:0] TOP_SEND    = 8'h80;
    localparam logic [7:0] TOP_TREAT   = 8'hC0;

    // check mode codes
    localparam logic [1:0] MODE_EASY  = 2'd0;
    localparam logic [1:0] MODE_SEND  = 2'd1;
    localparam logic [1:0] MODE_TREAT = 2'd2;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // configuration register indexes and reset values
    localparam logic       CFG_START   = 1'b0;
    localparam logic       CFG_END     = 1'b1;
    localparam logic [7:0] START_RESET = 8'd2;
    localparam logic [7:0] END_RESET   = 8'd3;

    typedef logic [7:0] t_byte;

    // record pushed by the front: raw frame state, formatted by the back
    typedef struct packed {
        logic                       kind;
        t_byte                      data;
        logic [LEN_W-1:0]           length;
        t_byte                      subs_seen;
        logic [1:0]                 mode;
        logic [HDR_FIELDS-1:0][7:0] hdr;
        logic [SUB_SLOTS-1:0][7:0]  subs;
    } t_rec;

    // fully formatted result
    typedef struct packed {
        logic       kind;
        t_byte      payload_byte;
        logic       frame_ok;
        logic [5:0] main_command;
        logic [1:0] check_mode;
        t_byte      message_id;
        t_byte      sender_id;
        t_byte      target_id;
        t_byte      sub_count;
        t_byte      sub_first;
        t_byte      sub_second;
        t_byte      sub_third;
    } t_res;

    // value minus bias, floored at zero
    function automatic t_byte decode_byte(input t_byte b);
        decode_byte = (b < DECODE_BIAS) ? 8'd0 : t_byte'(b - DECODE_BIAS);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/delimited_command_frame_parser_core.sv
// ============================================================================
// delimited_command_frame_parser_core - delimited command frame parser
// Each result beat is registered first in the result queue, then in the output register.
// Throughput: one byte per cycle; input stalls only when the 4-entry result
//   queue is full, i.e. when the receiver has held off for several beats.
// Reset (synchronous, active low): delimiters return to 2 and 3, frame state
//   clears, queue empties and output valid clears; no clearing pass.
// ============================================================================
`default_nettype none

module delimited_command_frame_parser_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration: index 0 start delimiter, index 1 end delimiter
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    // byte input
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    // result output
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_kind,
    output logic [7:0]      o_payload_byte,
    output logic            o_frame_ok,
    output logic [5:0]      o_main_command,
    output logic [1:0]      o_check_mode,
    output logic [7:0]      o_message_id,
    output logic [7:0]      o_sender_id,
    output logic [7:0]      o_target_id,
    output logic [7:0]      o_sub_count,
    output logic [7:0]      o_sub_first,
    output logic [7:0]      o_sub_second,
    output logic [7:0]      o_sub_third
);

    // front -> queue
    logic            push;
    dcfp_pkg::t_rec  push_rec;
    logic            in_accept;
    logic            q_full;

    // queue -> back
    logic            q_valid;
    dcfp_pkg::t_rec  q_rec;
    logic            q_pop;

    dcfp_pkg::t_res  res;

    // The front can push at most one record per accepted byte, so holding
    // input whenever the queue is full is enough to never overflow it.
    assign o_stall   = q_full;
    assign in_accept = i_valid && !q_full;

    dcfp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (in_accept),
        .i_byte     (i_in_byte),
        .o_push     (push),
        .o_rec      (push_rec)
    );

    // decouples classification from the output handshake
    dcfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rec   (q_rec),
        .o_full  (q_full)
    );

    // formats summaries and registers the outgoing beat
    dcfp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_rec   (q_rec),
        .o_pop   (q_pop),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (res)
    );

    assign o_kind         = res.kind;
    assign o_payload_byte = res.payload_byte;
    assign o_frame_ok     = res.frame_ok;
    assign o_main_command = res.main_command;
    assign o_check_mode   = res.check_mode;
    assign o_message_id   = res.message_id;
    assign o_sender_id    = res.sender_id;
    assign o_target_id    = res.target_id;
    assign o_sub_count    = res.sub_count;
    assign o_sub_first    = res.sub_first;
    assign o_sub_second   = res.sub_second;
    assign o_sub_third    = res.sub_third;

endmodule

`default_nettype wire

### hw/rtl/dcfp_front.sv
// ============================================================================
// dcfp_front - byte classifier and frame state
// Tracks delimiters, header, sub-commands and payload stop; pushes one
// record per payload byte or frame end.
// ============================================================================
`default_nettype none

module dcfp_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_idx,
    input  wire logic [7:0]           i_cfg_data,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_byte,
    output logic                      o_push,
    output dcfp_pkg::t_rec            o_rec
);

    logic [7:0]                                    r_start, r_end;
    logic                                          r_inside, n_inside;
    logic [dcfp_pkg::LEN_W-1:0]                    r_len, n_len, len_inc;
    logic [dcfp_pkg::HDR_FIELDS-1:0][7:0]          r_hdr, n_hdr;
    logic [dcfp_pkg::SUB_SLOTS-1:0][7:0]           r_subs, n_subs;
    logic [7:0]                                    r_subs_seen, n_subs_seen;
    logic                                          r_stopped, n_stopped;
    logic [1:0]                                    r_mode, n_mode;
    logic [7:0]                                    top;

    assign len_inc = (r_len < dcfp_pkg::LEN_W'(dcfp_pkg::MAX_FRAME))
                   ? r_len + dcfp_pkg::LEN_W'(1) : r_len;
    assign top     = i_byte & dcfp_pkg::TOP_MASK;

    always_comb begin
        n_inside    = r_inside;
        n_len       = r_len;
        n_hdr       = r_hdr;
        n_subs      = r_subs;
        n_subs_seen = r_subs_seen;
        n_stopped   = r_stopped;
        n_mode      = r_mode;
        o_push      = 1'b0;
        o_rec       = '0;

        if (i_accept) begin
            if (!r_inside) begin
                if (i_byte == r_start) begin
                    n_hdr       = '0;
                    n_subs      = '0;
                    n_subs_seen = '0;
                    n_stopped   = 1'b0;
                    n_mode      = dcfp_pkg::MODE_EASY;
                    if (i_byte == r_end) begin
                        // opener also closes: empty, bad frame
                        o_push       = 1'b1;
                        o_rec.kind   = dcfp_pkg::KIND_SUMMARY;
                        o_rec.length = dcfp_pkg::LEN_W'(1);
                        n_inside     = 1'b0;
                        n_len        = '0;
                    end else begin
                        n_inside = 1'b1;
                        n_len    = dcfp_pkg::LEN_W'(1);
                    end
                end
            end else if (i_byte == r_end) begin
                o_push          = 1'b1;
                o_rec.kind      = dcfp_pkg::KIND_SUMMARY;
                o_rec.length    = len_inc;
                o_rec.subs_seen = r_subs_seen;
                o_rec.mode      = r_mode;
                o_rec.hdr       = r_hdr;
                o_rec.subs      = r_subs;
                n_inside        = 1'b0;
                n_len           = '0;
                n_hdr           = '0;
                n_subs          = '0;
                n_subs_seen     = '0;
                n_stopped       = 1'b0;
                n_mode          = dcfp_pkg::MODE_EASY;
            end else begin
                if (r_len == dcfp_pkg::LEN_W'(dcfp_pkg::HDR_FIRST)) begin
                    if (top == dcfp_pkg::TOP_SEND) begin
                        n_mode = dcfp_pkg::MODE_SEND;
                    end else if (top == dcfp_pkg::TOP_TREAT) begin
                        n_mode = dcfp_pkg::MODE_TREAT;
                    end else begin
                        n_mode = dcfp_pkg::MODE_EASY;
                    end
                    n_hdr[0] = dcfp_pkg::decode_byte(i_byte & dcfp_pkg::CMD_MASK);
                end else if (r_len > dcfp_pkg::LEN_W'(dcfp_pkg::HDR_FIRST) &&
                             r_len <= dcfp_pkg::LEN_W'(dcfp_pkg::HDR_LAST)) begin
                    for (int i = 1; i < dcfp_pkg::HDR_FIELDS; i++) begin
                        if (r_len == dcfp_pkg::LEN_W'(i + dcfp_pkg::HDR_FIRST)) begin
                            n_hdr[i] = dcfp_pkg::decode_byte(i_byte);
                        end
                    end
                end else if (r_subs_seen < r_hdr[dcfp_pkg::HDR_FIELDS-1]) begin
                    if (r_subs_seen < 8'(dcfp_pkg::KEPT_SUBS)) begin
                        n_subs[r_subs_seen[dcfp_pkg::SUB_IDX_W-1:0]] =
                            dcfp_pkg::decode_byte(i_byte);
                    end
                    n_subs_seen = r_subs_seen + 8'd1;
                end else if (!r_stopped) begin
                    if (i_byte == 8'd0) begin
                        n_stopped = 1'b1;
                    end else begin
                        o_push     = 1'b1;
                        o_rec.kind = dcfp_pkg::KIND_PAYLOAD;
                        o_rec.data = i_byte;
                    end
                end
                n_len = len_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= dcfp_pkg::START_RESET;
            r_end       <= dcfp_pkg::END_RESET;
            r_inside    <= 1'b0;
            r_len       <= '0;
            r_hdr       <= '0;
            r_subs      <= '0;
            r_subs_seen <= '0;
            r_stopped   <= 1'b0;
            r_mode      <= dcfp_pkg::MODE_EASY;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dcfp_pkg::CFG_START: r_start <= i_cfg_data;
                    dcfp_pkg::CFG_END:   r_end   <= i_cfg_data;
                    default: ;
                endcase
            end
            r_inside    <= n_inside;
            r_len       <= n_len;
            r_hdr       <= n_hdr;
            r_subs      <= n_subs;
            r_subs_seen <= n_subs_seen;
            r_stopped   <= n_stopped;
            r_mode      <= n_mode;
        end
    end

    a_len_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= dcfp_pkg::LEN_W'(dcfp_pkg::MAX_FRAME))
        else $error("frame length past saturation");
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_inside |-> (r_len == '0 && r_subs_seen == '0 && !r_stopped))
        else $error("frame state left over outside a frame");
    a_subs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_subs_seen <= r_hdr[dcfp_pkg::HDR_FIELDS-1])
        else $error("more sub-commands counted than announced");

endmodule

`default_nettype wire

### hw/rtl/dcfp_queue.sv
// ============================================================================
// dcfp_queue - short record queue between classifier and output stage
// Register-based circular buffer; head is read in place.
// ============================================================================
`default_nettype none

module dcfp_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  dcfp_pkg::t_rec      i_rec,
    input  wire logic           i_pop,
    output logic                o_valid,
    output dcfp_pkg::t_rec      o_rec,
    output logic                o_full
);

    dcfp_pkg::t_rec                r_mem [dcfp_pkg::QUEUE_DEPTH];
    logic [dcfp_pkg::QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [dcfp_pkg::QCNT_W-1:0]   r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == dcfp_pkg::QCNT_W'(dcfp_pkg::QUEUE_DEPTH));
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + dcfp_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + dcfp_pkg::QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + dcfp_pkg::QCNT_W'(1);
                2'b01:   r_count <= r_count - dcfp_pkg::QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

### hw/rtl/dcfp_back.sv
// ============================================================================
// dcfp_back - result formatting and output register
// Computes the frame verdict, zeroes unused fields, holds the beat until
// the receiver takes it.
// ============================================================================
`default_nettype none

module dcfp_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  dcfp_pkg::t_rec      i_rec,
    output logic                o_pop,
    input  wire logic           i_stall,
    output logic                o_valid,
    output dcfp_pkg::t_res      o_res
);

    logic                        r_valid;
    dcfp_pkg::t_res              r_res, n_res;
    logic [dcfp_pkg::LEN_W-1:0]  need_len;
    logic [7:0]                  hdr_subs;

    assign hdr_subs = i_rec.hdr[dcfp_pkg::HDR_FIELDS-1];
    assign need_len = dcfp_pkg::LEN_W'(dcfp_pkg::HDR_LAST + 1)
                    + dcfp_pkg::LEN_W'(hdr_subs);
    assign o_pop    = i_valid && (!r_valid || !i_stall);

    always_comb begin
        n_res = '0;
        if (i_rec.kind == dcfp_pkg::KIND_PAYLOAD) begin
            n_res.kind         = dcfp_pkg::KIND_PAYLOAD;
            n_res.payload_byte = i_rec.data;
        end else begin
            n_res.kind         = dcfp_pkg::KIND_SUMMARY;
            n_res.frame_ok     = (i_rec.length >= need_len) &&
                                 (i_rec.subs_seen >= hdr_subs) &&
                                 (i_rec.length < dcfp_pkg::LEN_W'(dcfp_pkg::MAX_FRAME));
            n_res.main_command = i_rec.hdr[0][5:0];
            n_res.check_mode   = i_rec.mode;
            n_res.message_id   = i_rec.hdr[1];
            n_res.sender_id    = i_rec.hdr[2];
            n_res.target_id    = i_rec.hdr[3];
            n_res.sub_count    = i_rec.hdr[4];
            n_res.sub_first    = i_rec.subs[0];
            n_res.sub_second   = i_rec.subs[1];
            n_res.sub_third    = i_rec.subs[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.kind == dcfp_pkg::KIND_PAYLOAD) |-> (r_res.payload_byte != 8'd0))
        else $error("zero byte emitted as payload");

endmodule

`default_nettype wire
